@@ hdl/s256_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 message hasher.
// Used by s256_ctrl, s256_dp and sha256_message_hasher. No dependencies.
package s256_pkg;

  // Block geometry and padding constants.
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned LenStart   = 56;
  localparam int unsigned FillW      = $clog2(BlockBytes);
  localparam int unsigned RndW       = $clog2(Rounds);
  localparam logic [7:0]  PadMarker  = 8'h80;

  typedef logic [31:0] word_t;

  // Round constants.
  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial chaining value.
  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_PADZ,
    S_PADLEN,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_e;

  // Source of the byte shifted into the block buffer.
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            shift;
    src_e            src;
    logic            init;
    logic            round;
    logic [RndW-1:0] rnd;
    logic            fold;
    logic            emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FillW-1:0] fill;
  } sts_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t ch_f(word_t e, word_t f, word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t maj_f(word_t a, word_t b, word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ hdl/s256_dp.sv @@
// Datapath of the SHA-256 hasher: block buffer and schedule window, byte and
// length counters, round unit, chaining state and digest register. Uses s256_pkg.
module s256_dp import s256_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   data_byte_i,
  input  cmd_t         cmd_i,
  output sts_t         sts_o,
  output logic [63:0]  digest_part0_o,
  output logic [63:0]  digest_part1_o,
  output logic [63:0]  digest_part2_o,
  output logic [63:0]  digest_part3_o
);

  logic [511:0]       win_q;
  logic [FillW-1:0]   fill_q;
  logic [60:0]        cnt_q;
  word_t              chain_q [8];
  word_t              var_q [8];
  logic [255:0]       dig_q;

  logic [63:0]        bit_len;
  logic [2:0]         len_idx;
  logic [7:0]         len_byte;
  logic [7:0]         in_byte;
  word_t              w0, w1, w9, w14, w_new;
  word_t              t1, t2;

  // The length goes out most significant byte first while fill runs 56 to 63.
  assign bit_len  = {cnt_q, 3'b000};
  assign len_idx  = ~fill_q[2:0];
  assign len_byte = bit_len[{len_idx, 3'b000} +: 8];

  // Byte source selection.
  always_comb begin
    case (cmd_i.src)
      SRC_DATA: in_byte = data_byte_i;
      SRC_MARK: in_byte = PadMarker;
      SRC_ZERO: in_byte = 8'h00;
      SRC_LEN:  in_byte = len_byte;
      default:  in_byte = 8'h00;
    endcase
  end

  // Schedule taps: the window holds W[t] to W[t+15], W[t] at the top.
  assign w0    = win_q[511:480];
  assign w1    = win_q[479:448];
  assign w9    = win_q[223:192];
  assign w14   = win_q[63:32];
  assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

  // One compression round.
  assign t1 = var_q[7] + bsig1(var_q[4]) + ch_f(var_q[4], var_q[5], var_q[6])
            + RoundK[cmd_i.rnd] + w0;
  assign t2 = bsig0(var_q[0]) + maj_f(var_q[0], var_q[1], var_q[2]);

  // Block buffer doubles as the rolling schedule during rounds.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      win_q <= {win_q[503:0], in_byte};
    end else if (cmd_i.round) begin
      win_q <= {win_q[479:0], w_new};
    end
  end

  // Working variables a to h.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      var_q <= chain_q;
    end else if (cmd_i.round) begin
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1 + t2;
    end
  end

  // Digest register, loaded from the chaining state at the end of a message.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      dig_q <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3],
                chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
    end
  end

  // Fill and message length counters, chaining state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      cnt_q   <= '0;
      chain_q <= InitHash;
    end else begin
      if (cmd_i.shift) begin
        fill_q <= fill_q + 1'b1;
        if (cmd_i.src == SRC_DATA) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + var_q[i];
        end
      end else if (cmd_i.emit) begin
        chain_q <= InitHash;
        cnt_q   <= '0;
      end
    end
  end

  assign sts_o.fill     = fill_q;
  assign digest_part0_o = dig_q[255:192];
  assign digest_part1_o = dig_q[191:128];
  assign digest_part2_o = dig_q[127:64];
  assign digest_part3_o = dig_q[63:0];

endmodule

@@ hdl/s256_ctrl.sv @@
// Controller of the SHA-256 hasher: input and output handshakes, padding
// sequence, round counter and compression sequencing. Uses s256_pkg.
module s256_ctrl import s256_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic has_byte_i,
  input  logic last_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e          state_q, state_d;
  state_e          resume_q, resume_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic            out_valid_q;
  logic            wrap;
  logic            at_len;
  logic            out_free;

  assign wrap     = (sts_i.fill == FillW'(BlockBytes - 1));
  assign at_len   = (sts_i.fill == FillW'(LenStart));
  assign out_free = !out_valid_q || out_ready_i;

  // Next state. A byte that fills the block starts a compression, which then
  // resumes at the state recorded in resume_q.
  always_comb begin
    state_d  = state_q;
    resume_d = resume_q;
    rnd_d    = rnd_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (has_byte_i && wrap) begin
            state_d  = S_ROUND;
            resume_d = last_i ? S_PAD80 : S_IDLE;
          end else if (last_i) begin
            state_d = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        if (wrap) begin
          state_d  = S_ROUND;
          resume_d = S_PADZ;
        end else begin
          state_d = S_PADZ;
        end
      end
      S_PADZ: begin
        if (at_len) begin
          state_d = S_PADLEN;
        end else if (wrap) begin
          state_d  = S_ROUND;
          resume_d = S_PADZ;
        end
      end
      S_PADLEN: begin
        if (wrap) begin
          state_d  = S_ROUND;
          resume_d = S_EMIT;
        end
      end
      S_ROUND: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RndW'(Rounds - 1)) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: state_d = resume_q;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands and input ready.
  always_comb begin
    cmd_o      = '0;
    cmd_o.src  = SRC_DATA;
    cmd_o.rnd  = rnd_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && has_byte_i) begin
          cmd_o.shift = 1'b1;
          cmd_o.init  = wrap;
        end
      end
      S_PAD80: begin
        cmd_o.shift = 1'b1;
        cmd_o.src   = SRC_MARK;
        cmd_o.init  = wrap;
      end
      S_PADZ: begin
        if (!at_len) begin
          cmd_o.shift = 1'b1;
          cmd_o.src   = SRC_ZERO;
          cmd_o.init  = wrap;
        end
      end
      S_PADLEN: begin
        cmd_o.shift = 1'b1;
        cmd_o.src   = SRC_LEN;
        cmd_o.init  = wrap;
      end
      S_ROUND: cmd_o.round = 1'b1;
      S_FOLD:  cmd_o.fold  = 1'b1;
      S_EMIT:  cmd_o.emit  = out_free;
      default: ;
    endcase
  end

  // State, resume point, round counter and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      resume_q    <= S_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
      rnd_q    <= rnd_d;
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // The last round always hands over to the fold.
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == RndW'(Rounds - 1)) |=> state_q == S_FOLD)
    else $error("round sequence did not end in fold");

  // Loading the working variables starts round zero in the next cycle.
  a_init_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.init |=> (state_q == S_ROUND && rnd_q == '0))
    else $error("compression did not start at round zero");

  // A digest is only produced once the final block has been consumed.
  a_emit_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> sts_i.fill == '0)
    else $error("emit with bytes still pending");

  // An emitted digest shows up as valid in the next cycle.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("digest emitted without valid");

endmodule

@@ hdl/sha256_message_hasher.sv @@
// Top level of the SHA-256 message hasher: joins the controller and datapath.
// Depends on s256_pkg, s256_ctrl and s256_dp.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid_i / in_ready_o    data_byte_i, has_byte_i, last_i
//   output    out        out_valid_o / out_ready_i  digest_part0_o .. digest_part3_o
//
// A byte that completes a 64-byte block starts a compression: 64 rounds on the
// single round unit, then a fold. A last item then pads the message: the 0x80
// marker and zero bytes, a turn-around state at fill 56, the eight length bytes,
// a compression per block filled and the emit; the most work is when 56 bytes
// are pending and a second block is needed. Input is taken only while idle; the
// emit cycle waits while an earlier digest is still untaken. Reset loads the
// initial hash values; no clearing pass.
module sha256_message_hasher import s256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_part0_o,
  output logic [63:0] digest_part1_o,
  output logic [63:0] digest_part2_o,
  output logic [63:0] digest_part3_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  s256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hashing datapath.
  s256_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (data_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .digest_part0_o (digest_part0_o),
    .digest_part1_o (digest_part1_o),
    .digest_part2_o (digest_part2_o),
    .digest_part3_o (digest_part3_o)
  );

endmodule

@@ tb/sha256_message_hasher_tb.sv @@
// Self-checking testbench for sha256_message_hasher: byte streams in, digests out.
// Holds its own SHA-256 predictor in a scoreboard class; depends only on the RTL
// under test (s256_pkg, s256_ctrl, s256_dp, sha256_message_hasher).
`timescale 1ns / 1ps

// Predicts the digest of every message seen on the input channel and checks
// the digests that come out against them in order.
class digest_scoreboard;

  typedef bit [255:0] digest_t;

  // SHA-256 round constants, round 0 in the top word.
  localparam bit [64*32-1:0] RoundConst = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial chaining value, word 0 in the top bits.
  localparam bit [255:0] HashInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  bit [31:0]   chain [8];
  bit [7:0]    block_buf [64];
  int unsigned fill;
  bit [60:0]   byte_count;
  digest_t     expected_q [$];
  int unsigned errors;
  int unsigned digests_checked;

  function new();
    errors = 0;
    digests_checked = 0;
    restart();
  endfunction

  // Back to the initial hash values with an empty message.
  function void restart();
    for (int i = 0; i < 8; i++) begin
      chain[i] = HashInit[255-32*i -: 32];
    end
    for (int i = 0; i < 64; i++) begin
      block_buf[i] = 8'h00;
    end
    fill = 0;
    byte_count = '0;
  endfunction

  function bit [31:0] ror(bit [31:0] x, int unsigned n);
    bit [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  // Full schedule expansion and 64 rounds over the buffered block.
  function void compress();
    bit [31:0] w [64];
    bit [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d} = {chain[0], chain[1], chain[2], chain[3]};
    {e, f, g, h} = {chain[4], chain[5], chain[6], chain[7]};
    for (int r = 0; r < 64; r++) begin
      s1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
      t1 = h + s1 + ((e & f) ^ (~e & g)) + RoundConst[(63-r)*32 +: 32] + w[r];
      s0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
    chain[5] += f;
    chain[6] += g;
    chain[7] += h;
  endfunction

  // Applies one accepted input transfer; a last transfer pads the message
  // and queues its digest.
  function void note_input(bit [7:0] data, bit has_byte, bit last);
    bit [63:0] bit_len;
    if (has_byte) begin
      block_buf[fill] = data;
      byte_count++;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (!last) begin
      return;
    end
    block_buf[fill] = 8'h80;
    for (int i = fill + 1; i < 64; i++) begin
      block_buf[i] = 8'h00;
    end
    // No room for the length field: an extra block is needed.
    if (fill >= 56) begin
      compress();
      for (int i = 0; i < 64; i++) begin
        block_buf[i] = 8'h00;
      end
    end
    bit_len = {byte_count, 3'b000};
    for (int i = 0; i < 8; i++) begin
      block_buf[63-i] = bit_len[8*i +: 8];
    end
    compress();
    expected_q.push_back({chain[0], chain[1], chain[2], chain[3],
                          chain[4], chain[5], chain[6], chain[7]});
    restart();
  endfunction

  // Compares one digest transfer with the oldest expected digest.
  function void check_digest(logic [63:0] p0, logic [63:0] p1,
                             logic [63:0] p2, logic [63:0] p3);
    digest_t     want;
    logic [63:0] got [4];
    if (expected_q.size() == 0) begin
      $error("digest transfer with no message pending: %h %h %h %h", p0, p1, p2, p3);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    got[0] = p0;
    got[1] = p1;
    got[2] = p2;
    got[3] = p3;
    for (int i = 0; i < 4; i++) begin
      if (got[i] !== want[255-64*i -: 64]) begin
        $error("digest_part%0d mismatch: expected %h, actual %h",
               i, want[255-64*i -: 64], got[i]);
        errors++;
      end
    end
    digests_checked++;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

endclass

module sha256_message_hasher_tb;

  localparam int unsigned ItemTarget  = 700;
  localparam int unsigned MinMessages = 20;
  localparam int unsigned HoldCycles  = 2000;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned TailCycles  = 300;
  localparam int unsigned TimeoutNs   = 10_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        has_byte_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] digest_part0_o;
  logic [63:0] digest_part1_o;
  logic [63:0] digest_part2_o;
  logic [63:0] digest_part3_o;

  digest_scoreboard sb = new();

  bit          sender_gaps   = 1'b1;
  bit          receiver_gaps = 1'b1;
  bit          hold_req      = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned null_steps    = 0;
  int unsigned messages      = 0;
  int unsigned holds_done    = 0;

  sha256_message_hasher u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .has_byte_i     (has_byte_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_part0_o (digest_part0_o),
    .digest_part1_o (digest_part1_o),
    .digest_part2_o (digest_part2_o),
    .digest_part3_o (digest_part3_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Offers one input transfer and waits for it to be taken.
  task automatic send_item(input bit [7:0] data, input bit has_byte, input bit last);
    int unsigned gap;
    gap = sender_gaps ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    has_byte_i  <= has_byte;
    last_i      <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(data, has_byte, last);
    if (!has_byte && !last) begin
      null_steps++;
    end else begin
      items_sent++;
    end
    if (has_byte) begin
      bytes_sent++;
    end
    if (last) begin
      messages++;
    end
    @(negedge clk_i);
  endtask

  // Sends one message of len bytes, closed either on its final byte or by a
  // bare end marker, with empty steps mixed in now and then.
  task automatic send_message(input int unsigned len, input bit bare_end,
                              input int unsigned fill_kind, input int unsigned noise_pct);
    bit [7:0] data;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      case (fill_kind)
        1: begin
          data = 8'h00;
        end
        2: begin
          data = 8'hff;
        end
        default: begin
          data = 8'($urandom_range(0, 255));
        end
      endcase
      send_item(data, 1'b1, !bare_end && (i == len - 1));
    end
    if (bare_end || len == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // Length mix: mostly short, weighted towards the padding boundaries around 56, 64 and 120.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return $urandom_range(0, 12);
    end
    if (r < 85) begin
      case ($urandom_range(0, 7))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        default: return 120;
      endcase
    end
    return $urandom_range(0, 130);
  endfunction

  // Receiver: random stalls, a quiet stretch on request and one long hold-off.
  initial begin : ready_drive
    int unsigned stall_left;
    out_ready_i = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        out_ready_i <= 1'b1;
        holds_done++;
      end else if (!receiver_gaps) begin
        out_ready_i <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 75) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(15, 60);
      end
    end
  end

  // Digest transfers are checked at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_digest(digest_part0_o, digest_part1_o, digest_part2_o, digest_part3_o);
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TimeoutNs);
    $display("TEST FAILED");
    $finish;
  end

  // Reset, directed messages, random messages, then drain.
  initial begin
    int unsigned n;
    int unsigned waited;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    has_byte_i  = 1'b0;
    last_i      = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty message from a bare end marker, then again after empty steps.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // Single-byte messages at both extremes of the byte.
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    // "abc" closed on its final byte, then closed by a bare end marker.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);

    // Random messages until both the item and the digest counts are reached.
    n = 0;
    while (items_sent < ItemTarget || messages < MinMessages) begin
      if (n == 4) begin
        // Receiver holds off while short messages keep arriving back to back.
        hold_req = 1'b1;
        sender_gaps = 1'b0;
        for (int i = 0; i < 6; i++) begin
          send_message($urandom_range(0, 8), $urandom_range(0, 1) == 1, 0, 0);
        end
      end
      sender_gaps   = !(n >= 10 && n < 14);
      receiver_gaps = !(n >= 10 && n < 14);
      send_message(pick_len(), $urandom_range(0, 3) == 0,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0, 5);
      n++;
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d digests never arrived", sb.pending());
      sb.errors++;
    end

    $display("Hashed %0d messages from %0d bytes (%0d items, %0d empty steps).",
             messages, bytes_sent, items_sent, null_steps);
    $display("Checked %0d digests; %0d long receiver hold-off(s) applied.",
             sb.digests_checked, holds_done);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
